// ===== hdl/vmnn_pkg.sv =====
// ----------------------------------------------------------------------------
// vmnn_pkg
// Shared types, constants and the neighbor shift table of the voxel map.
// ----------------------------------------------------------------------------
package vmnn_pkg;

  localparam int TABLE_SLOTS_DEF     = 4096;
  localparam int POINTS_PER_SLOT_DEF = 32;

  localparam int COORD_W   = 24;
  localparam int VS_W      = 16;
  localparam int MP_W      = 6;
  localparam int CNT_W     = 7;   // holds a point count up to the largest slot size
  localparam int DIST_W    = 18;
  localparam int STATUS_W  = 2;
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 17;  // voxel size and the largest table size
  localparam int SQ_W      = 50;  // sum of three squared 25-bit differences
  localparam int ROOT_W    = 25;
  localparam int NBR_W     = 5;
  localparam int NBR_COUNT = 27;

  localparam logic [VS_W-1:0]   VOXEL_SIZE_RST = 16'd1000;
  localparam logic [MP_W-1:0]   MAX_POINTS_RST = 6'd20;
  localparam logic [DIST_W-1:0] DIST_MAX       = 18'h3FFFF;

  localparam logic [31:0] HASH_X = 32'd73856093;
  localparam logic [31:0] HASH_Y = 32'd19349663;
  localparam logic [31:0] HASH_Z = 32'd83492791;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED, ST_VOXEL_FULL, ST_TABLE_FULL, ST_QUERY
  } status_t;

  typedef enum logic {KIND_INSERT, KIND_QUERY} kind_t;

  typedef enum logic {REG_VOXEL_SIZE, REG_MAX_POINTS} reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_NBR, S_HASH, S_MOD, S_MOD_WAIT,
    S_PROBE_RD, S_PROBE_CHK, S_INS_NEW, S_INS_HIT, S_PT_RD, S_PT_SQ, S_PT_CMP,
    S_NBR_NEXT, S_SQRT_GO, S_SQRT_WAIT, S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } shift_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] kx;
    logic signed [COORD_W-1:0] ky;
    logic signed [COORD_W-1:0] kz;
    logic [CNT_W-1:0]          count;
  } slot_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  localparam logic signed [1:0] P = 2'sb01;
  localparam logic signed [1:0] Z = 2'sb00;
  localparam logic signed [1:0] N = 2'sb11;

  // Neighbor order: center, faces, edges, corners.
  function automatic shift_t nbr_shift(input logic [NBR_W-1:0] idx);
    shift_t s;
    case (idx)
      5'd0:    s = '{Z, Z, Z};
      5'd1:    s = '{P, Z, Z};
      5'd2:    s = '{N, Z, Z};
      5'd3:    s = '{Z, P, Z};
      5'd4:    s = '{Z, N, Z};
      5'd5:    s = '{Z, Z, P};
      5'd6:    s = '{Z, Z, N};
      5'd7:    s = '{P, P, Z};
      5'd8:    s = '{P, N, Z};
      5'd9:    s = '{N, P, Z};
      5'd10:   s = '{N, N, Z};
      5'd11:   s = '{P, Z, P};
      5'd12:   s = '{P, Z, N};
      5'd13:   s = '{N, Z, P};
      5'd14:   s = '{N, Z, N};
      5'd15:   s = '{Z, P, P};
      5'd16:   s = '{Z, P, N};
      5'd17:   s = '{Z, N, P};
      5'd18:   s = '{Z, N, N};
      5'd19:   s = '{P, P, P};
      5'd20:   s = '{P, P, N};
      5'd21:   s = '{P, N, P};
      5'd22:   s = '{P, N, N};
      5'd23:   s = '{N, P, P};
      5'd24:   s = '{N, P, N};
      5'd25:   s = '{N, N, P};
      5'd26:   s = '{N, N, N};
      default: s = '{Z, Z, Z};
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/vmnn_if.sv =====
// ----------------------------------------------------------------------------
// vmnn_if
// Request and response channels of the voxel map (valid/ready handshake).
// ----------------------------------------------------------------------------
interface vmnn_req_if;
  import vmnn_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] x_mm;
  logic signed [COORD_W-1:0] y_mm;
  logic signed [COORD_W-1:0] z_mm;

  modport source (output valid, kind, x_mm, y_mm, z_mm, input ready);
  modport sink   (input valid, kind, x_mm, y_mm, z_mm, output ready);
endinterface

interface vmnn_rsp_if;
  import vmnn_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      found;
  logic signed [COORD_W-1:0] near_x;
  logic signed [COORD_W-1:0] near_y;
  logic signed [COORD_W-1:0] near_z;
  logic [DIST_W-1:0]         distance;

  modport source (output valid, status, found, near_x, near_y, near_z, distance,
                  input ready);
  modport sink   (input valid, status, found, near_x, near_y, near_z, distance,
                  output ready);
endinterface

// ===== hdl/vmnn_div.sv =====
// ----------------------------------------------------------------------------
// vmnn_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vmnn_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vmnn_pkg::div_req_t req,
  output vmnn_pkg::div_rsp_t rsp
);
  import vmnn_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_NUM_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 take;
  logic [DIV_DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_NUM_W-1]};
    take    = rem_sh >= {1'b0, den_r};
    rem_nxt = take ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_NUM_W-2:0], take};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hdl/vmnn_isqrt.sv =====
// ----------------------------------------------------------------------------
// vmnn_isqrt
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vmnn_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  vmnn_pkg::sqrt_req_t req,
  output vmnn_pkg::sqrt_rsp_t rsp
);
  import vmnn_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic               busy_r;
  logic               done_r;
  logic [4:0]         cnt_r;
  logic [SQ_W-1:0]    val_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               take;

  always_comb begin
    rem_sh = {rem_r, val_r[SQ_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        val_r  <= req.value;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        val_r  <= {val_r[SQ_W-3:0], 2'b00};
        rem_r  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], take};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == 5'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ===== hdl/vmnn_slot_mem.sv =====
// ----------------------------------------------------------------------------
// vmnn_slot_mem
// Hash table of voxel slots: key, point count and valid flag per slot.
// ----------------------------------------------------------------------------
module vmnn_slot_mem #(
  parameter int TABLE_SLOTS = vmnn_pkg::TABLE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(TABLE_SLOTS)-1:0] waddr,
  input  vmnn_pkg::slot_t                wdata,
  input  logic [$clog2(TABLE_SLOTS)-1:0] raddr,
  output vmnn_pkg::slot_t                rdata
);
  import vmnn_pkg::*;

  slot_t mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/vmnn_point_mem.sv =====
// ----------------------------------------------------------------------------
// vmnn_point_mem
// Point store, a fixed block of entries per slot.
// ----------------------------------------------------------------------------
module vmnn_point_mem #(
  parameter int DEPTH = vmnn_pkg::TABLE_SLOTS_DEF * vmnn_pkg::POINTS_PER_SLOT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  vmnn_pkg::point_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output vmnn_pkg::point_t         rdata
);
  import vmnn_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/voxel_map_nearest_neighbor.sv =====
// ----------------------------------------------------------------------------
// voxel_map_nearest_neighbor
// Voxel hash map with insert and 27-voxel nearest neighbor query.
// ----------------------------------------------------------------------------
// Insert: accept, divide each axis for the voxel index, hash (the divider
//   also takes the modulo if TABLE_SLOTS is not a power of two), probe, then
//   write. Query: same index steps, then per neighbor voxel the hash, probes,
//   a read, square and compare per stored point and a step to advance, then a
//   square root; the result is loaded into the output register. One request
//   at a time, set by the shared divider and the single slot read port.
// Reset: a clearing pass over all TABLE_SLOTS slots empties the slot table;
//   no request is taken until it ends. Registers return to 1000 and 20.
// ----------------------------------------------------------------------------
module voxel_map_nearest_neighbor #(
  parameter int TABLE_SLOTS     = vmnn_pkg::TABLE_SLOTS_DEF,
  parameter int POINTS_PER_SLOT = vmnn_pkg::POINTS_PER_SLOT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  vmnn_req_if.sink                    in_req,
  vmnn_rsp_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [vmnn_pkg::VS_W-1:0]   cfg_wdata
);
  import vmnn_pkg::*;

  localparam int   SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int   DEPTH    = TABLE_SLOTS * POINTS_PER_SLOT;
  localparam int   PT_W     = $clog2(DEPTH);
  localparam bit   IS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  PPS_CNT   = CNT_W'(POINTS_PER_SLOT);

  state_t state_r, state_nxt;

  // configuration
  logic [VS_W-1:0] vs_r;
  logic [MP_W-1:0] mp_r;
  logic [VS_W-1:0] vs_eff;
  logic [CNT_W-1:0] lim;

  // request and working registers
  logic                      kind_r;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic signed [COORD_W-1:0] vox_r [3];
  logic [1:0]                axis_r;
  logic [NBR_W-1:0]          nbr_r;
  logic signed [COORD_W-1:0] kx_r, ky_r, kz_r;
  logic [31:0]               hx_r, hy_r, hz_r;
  logic [SLOT_W-1:0]         addr_r;
  logic [SLOT_W-1:0]         probe_r;
  logic [SLOT_W-1:0]         clr_r;
  slot_t                     ent_r;
  logic [CNT_W-1:0]          k_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r, sqz_r;
  point_t                    cand_r;
  logic                      have_r;
  logic [SQ_W-1:0]           best_r;
  point_t                    best_pt_r;

  // pending result and output register
  logic [STATUS_W-1:0] res_status_r;
  logic                res_found_r;
  point_t              res_pt_r;
  logic [DIST_W-1:0]   res_dist_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  point_t              out_pt_r;
  logic [DIST_W-1:0]   out_dist_r;

  // memories and shared units
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  slot_t             slot_wdata;
  slot_t             slot_rdata;
  logic              pt_we;
  logic [PT_W-1:0]   pt_waddr;
  point_t            pt_wdata;
  logic [PT_W-1:0]   pt_raddr;
  point_t            pt_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  sqrt_req_t         sqrt_req;
  sqrt_rsp_t         sqrt_rsp;

  // combinational helpers
  logic                      in_fire;
  logic                      emit_go;
  logic signed [COORD_W-1:0] coord_sel;
  logic [COORD_W-1:0]        coord_mag;
  logic signed [COORD_W-1:0] vidx;
  shift_t                    shf;
  logic signed [COORD_W:0]   nx, ny, nz;
  logic                      nbr_oor;
  logic [31:0]               hash;
  logic                      key_hit;
  logic [PT_W-1:0]           pt_base;
  logic signed [COORD_W:0]   dx, dy, dz;
  logic signed [SQ_W-1:0]    sqx, sqy, sqz;
  logic [SQ_W-1:0]           dsum;
  logic                      better;
  logic [SLOT_W-1:0]         addr_inc;

  assign vs_eff  = (vs_r == '0) ? VS_W'(1) : vs_r;
  assign lim     = (CNT_W'(mp_r) < PPS_CNT) ? CNT_W'(mp_r) : PPS_CNT;
  assign in_fire = in_req.valid && in_req.ready;
  assign emit_go = !out_valid_r || out_rsp.ready;

  always_comb begin
    case (axis_r)
      2'd0:    coord_sel = px_r;
      2'd1:    coord_sel = py_r;
      default: coord_sel = pz_r;
    endcase
    coord_mag = coord_sel[COORD_W-1] ? COORD_W'(-coord_sel) : coord_sel;
    // floor toward minus infinity for negative coordinates
    if (coord_sel[COORD_W-1]) begin
      vidx = -$signed(div_rsp.quo[COORD_W-1:0])
             - $signed(COORD_W'(div_rsp.rem != '0));
    end else begin
      vidx = $signed(div_rsp.quo[COORD_W-1:0]);
    end
  end

  always_comb begin
    shf     = nbr_shift(nbr_r);
    nx      = {vox_r[0][COORD_W-1], vox_r[0]} + (COORD_W+1)'(shf.dx);
    ny      = {vox_r[1][COORD_W-1], vox_r[1]} + (COORD_W+1)'(shf.dy);
    nz      = {vox_r[2][COORD_W-1], vox_r[2]} + (COORD_W+1)'(shf.dz);
    nbr_oor = (nx[COORD_W] != nx[COORD_W-1]) || (ny[COORD_W] != ny[COORD_W-1])
           || (nz[COORD_W] != nz[COORD_W-1]);
    hash    = hx_r ^ hy_r ^ hz_r;
    key_hit = (slot_rdata.kx == kx_r) && (slot_rdata.ky == ky_r)
           && (slot_rdata.kz == kz_r);
    addr_inc = (addr_r == LAST_SLOT) ? '0 : addr_r + 1'b1;
    pt_base = PT_W'(addr_r) * PT_W'(POINTS_PER_SLOT);
    dx      = {pt_rdata.x[COORD_W-1], pt_rdata.x} - {px_r[COORD_W-1], px_r};
    dy      = {pt_rdata.y[COORD_W-1], pt_rdata.y} - {py_r[COORD_W-1], py_r};
    dz      = {pt_rdata.z[COORD_W-1], pt_rdata.z} - {pz_r[COORD_W-1], pz_r};
    // full-width squares of the 25-bit differences
    sqx     = dx * dx;
    sqy     = dy * dy;
    sqz     = dz * dz;
    dsum    = sqx_r + sqy_r + sqz_r;
    better  = !have_r || (dsum < best_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:     if (clr_r == LAST_SLOT) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_req.kind == KIND_INSERT && lim == '0) ? S_EMIT : S_DIV_GO;
        end
      end
      S_DIV_GO:    state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) state_nxt = (axis_r == 2'd2) ? S_NBR : S_DIV_GO;
      end
      S_NBR:       state_nxt = nbr_oor ? S_NBR_NEXT : S_HASH;
      S_HASH:      state_nxt = S_MOD;
      S_MOD:       state_nxt = IS_POW2 ? S_PROBE_RD : S_MOD_WAIT;
      S_MOD_WAIT:  if (div_rsp.done) state_nxt = S_PROBE_RD;
      S_PROBE_RD:  state_nxt = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!slot_rdata.valid) begin
          state_nxt = (kind_r == KIND_INSERT) ? S_INS_NEW : S_NBR_NEXT;
        end else if (key_hit) begin
          if (kind_r == KIND_INSERT) state_nxt = S_INS_HIT;
          else state_nxt = (slot_rdata.count == '0) ? S_NBR_NEXT : S_PT_RD;
        end else if (probe_r == LAST_SLOT) begin
          state_nxt = (kind_r == KIND_INSERT) ? S_EMIT : S_NBR_NEXT;
        end else begin
          state_nxt = S_PROBE_RD;
        end
      end
      S_INS_NEW:   state_nxt = S_EMIT;
      S_INS_HIT:   state_nxt = S_EMIT;
      S_PT_RD:     state_nxt = S_PT_SQ;
      S_PT_SQ:     state_nxt = S_PT_CMP;
      S_PT_CMP:    state_nxt = (k_r + 1'b1 == ent_r.count) ? S_NBR_NEXT : S_PT_RD;
      S_NBR_NEXT: begin
        if (nbr_r == NBR_W'(NBR_COUNT - 1)) state_nxt = have_r ? S_SQRT_GO : S_EMIT;
        else state_nxt = S_NBR;
      end
      S_SQRT_GO:   state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: if (sqrt_rsp.done) state_nxt = S_EMIT;
      S_EMIT:      if (emit_go) state_nxt = S_IDLE;
      default:     state_nxt = S_CLEAR;
    endcase
  end

  // memory, unit and handshake controls
  always_comb begin
    in_req.ready   = 1'b0;
    slot_we        = 1'b0;
    slot_waddr     = addr_r;
    slot_wdata     = '0;
    pt_we          = 1'b0;
    pt_waddr       = pt_base;
    pt_wdata       = '{x: px_r, y: py_r, z: pz_r};
    pt_raddr       = pt_base + PT_W'(k_r);
    div_req        = '0;
    sqrt_req.start = 1'b0;
    sqrt_req.value = best_r;
    case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
      end
      S_IDLE:   in_req.ready = 1'b1;
      S_DIV_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(coord_mag);
        div_req.den   = DIV_DEN_W'(vs_eff);
      end
      S_MOD: begin
        div_req.start = !IS_POW2;
        div_req.num   = hash;
        div_req.den   = DIV_DEN_W'(TABLE_SLOTS);
      end
      S_INS_NEW: begin
        slot_we    = 1'b1;
        slot_wdata = '{valid: 1'b1, kx: kx_r, ky: ky_r, kz: kz_r, count: CNT_W'(1)};
        pt_we      = 1'b1;
      end
      S_INS_HIT: begin
        // store only while the voxel has room
        slot_we    = ent_r.count < lim;
        slot_wdata = '{valid: 1'b1, kx: kx_r, ky: ky_r, kz: kz_r,
                       count: ent_r.count + 1'b1};
        pt_we      = ent_r.count < lim;
        pt_waddr   = pt_base + PT_W'(ent_r.count);
      end
      S_SQRT_GO: sqrt_req.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= VOXEL_SIZE_RST;
      mp_r <= MAX_POINTS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_VOXEL_SIZE: vs_r <= cfg_wdata;
        REG_MAX_POINTS: mp_r <= cfg_wdata[MP_W-1:0];
        default: ;
      endcase
    end
  end

  // output register: drop on take, load when a result is ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_rsp.ready) out_valid_r <= 1'b0;
      if (state_r == S_EMIT && emit_go) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && emit_go) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_pt_r     <= res_pt_r;
      out_dist_r   <= res_dist_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          if (in_fire) begin
            kind_r       <= in_req.kind;
            px_r         <= in_req.x_mm;
            py_r         <= in_req.y_mm;
            pz_r         <= in_req.z_mm;
            axis_r       <= '0;
            nbr_r        <= '0;
            have_r       <= 1'b0;
            // insert defaults; a zero point limit drops right away
            res_status_r <= ST_VOXEL_FULL;
            res_found_r  <= 1'b0;
            res_pt_r     <= '0;
            res_dist_r   <= '0;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            vox_r[axis_r] <= vidx;
            axis_r        <= axis_r + 1'b1;
          end
        end
        S_NBR: begin
          kx_r <= nx[COORD_W-1:0];
          ky_r <= ny[COORD_W-1:0];
          kz_r <= nz[COORD_W-1:0];
        end
        S_HASH: begin
          hx_r <= 32'(kx_r) * HASH_X;
          hy_r <= 32'(ky_r) * HASH_Y;
          hz_r <= 32'(kz_r) * HASH_Z;
        end
        S_MOD: begin
          addr_r  <= hash[SLOT_W-1:0];
          probe_r <= '0;
        end
        S_MOD_WAIT: if (div_rsp.done) addr_r <= div_rsp.rem[SLOT_W-1:0];
        S_PROBE_CHK: begin
          ent_r <= slot_rdata;
          k_r   <= '0;
          if (slot_rdata.valid && !key_hit) begin
            probe_r <= probe_r + 1'b1;
            addr_r  <= addr_inc;
            if (probe_r == LAST_SLOT) res_status_r <= ST_TABLE_FULL;
          end
        end
        S_INS_NEW: res_status_r <= ST_STORED;
        S_INS_HIT: res_status_r <= (ent_r.count < lim) ? ST_STORED : ST_VOXEL_FULL;
        S_PT_SQ: begin
          sqx_r  <= sqx;
          sqy_r  <= sqy;
          sqz_r  <= sqz;
          cand_r <= pt_rdata;
        end
        S_PT_CMP: begin
          k_r <= k_r + 1'b1;
          if (better) begin
            have_r    <= 1'b1;
            best_r    <= dsum;
            best_pt_r <= cand_r;
          end
        end
        S_NBR_NEXT: begin
          nbr_r        <= nbr_r + 1'b1;
          res_status_r <= ST_QUERY;
          res_dist_r   <= DIST_MAX;
        end
        S_SQRT_WAIT: begin
          if (sqrt_rsp.done) begin
            res_found_r <= 1'b1;
            res_pt_r    <= best_pt_r;
            res_dist_r  <= (sqrt_rsp.root > ROOT_W'(DIST_MAX))
                           ? DIST_MAX : sqrt_rsp.root[DIST_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  vmnn_slot_mem #(.TABLE_SLOTS(TABLE_SLOTS)) u_slot_mem (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (addr_r),
    .rdata (slot_rdata)
  );

  vmnn_point_mem #(.DEPTH(DEPTH)) u_point_mem (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  vmnn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  vmnn_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.found    = out_found_r;
  assign out_rsp.near_x   = out_pt_r.x;
  assign out_rsp.near_y   = out_pt_r.y;
  assign out_rsp.near_z   = out_pt_r.z;
  assign out_rsp.distance = out_dist_r;

`ifndef SYNTHESIS
  a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_req.ready)
    else $error("request taken during clearing pass");

  a_point_with_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pt_we |-> slot_we)
    else $error("point written without slot count update");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_go) |=> out_valid_r)
    else $error("result not loaded into output register");
`endif

endmodule

// ===== sim/vmnn_checker.sv =====
// ----------------------------------------------------------------------------
// vmnn_checker
// Watches the voxel map channels, predicts each response and compares.
// ----------------------------------------------------------------------------
module vmnn_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  vmnn_req_if                       req,
  vmnn_rsp_if                       rsp,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [vmnn_pkg::VS_W-1:0] cfg_wdata,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vmnn_pkg::*;

  localparam int TS  = TABLE_SLOTS_DEF;
  localparam int PPS = POINTS_PER_SLOT_DEF;
  localparam int SHX [27] = '{0,1,-1,0,0,0,0,1,1,-1,-1,1,1,-1,-1,0,0,0,0,1,1,1,1,-1,-1,-1,-1};
  localparam int SHY [27] = '{0,0,0,1,-1,0,0,1,-1,1,-1,0,0,0,0,1,1,-1,-1,1,1,-1,-1,1,1,-1,-1};
  localparam int SHZ [27] = '{0,0,0,0,0,1,-1,0,0,0,0,1,-1,1,-1,1,-1,1,-1,1,-1,1,-1,1,-1,1,-1};

  typedef struct {
    status_t                   status;
    logic                      found;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic [DIST_W-1:0]         distance;
  } answer_t;

  answer_t     answers_due[$];
  int unsigned voxel_edge;
  int unsigned point_cap;
  bit          occupied [TS];
  int          vox_x [TS], vox_y [TS], vox_z [TS];
  int          fill [TS];
  int          pt_x [TS*PPS], pt_y [TS*PPS], pt_z [TS*PPS];

  assign pending = answers_due.size();

  function automatic int floor_idx(int c, int unsigned d);
    longint n, q;
    n = c;
    q = n / longint'(d);
    if ((n % longint'(d)) != 0 && n < 0) q--;
    return int'(q);
  endfunction

  // Linear probe: hit returns the voxel's slot, miss the first free one or -1.
  function automatic bit probe(int a, int b, int c, output int slot);
    int unsigned h;
    int s;
    h = (int'(a) * HASH_X) ^ (int'(b) * HASH_Y) ^ (int'(c) * HASH_Z);
    h = h % TS;
    for (int n = 0; n < TS; n++) begin
      s = (h + n) % TS;
      if (!occupied[s]) begin
        slot = s;
        return 0;
      end
      if (vox_x[s] == a && vox_y[s] == b && vox_z[s] == c) begin
        slot = s;
        return 1;
      end
    end
    slot = -1;
    return 0;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic answer_t serve(bit kind, int px, int py, int pz);
    answer_t a;
    int unsigned vs, lim;
    int vx, vy, vz, slot, p;
    longint nx, ny, nz, dx, dy, dz;
    longint unsigned d, best, root;
    bit have, hit;
    a = '{ST_STORED, 1'b0, '0, '0, '0, '0};
    vs = (voxel_edge == 0) ? 1 : voxel_edge;
    vx = floor_idx(px, vs);
    vy = floor_idx(py, vs);
    vz = floor_idx(pz, vs);
    if (kind == KIND_INSERT) begin
      lim = (point_cap < PPS) ? point_cap : PPS;
      hit = probe(vx, vy, vz, slot);
      if (lim == 0) begin
        a.status = ST_VOXEL_FULL;
        return a;
      end
      if (!hit) begin
        if (slot < 0) begin
          a.status = ST_TABLE_FULL;
          return a;
        end
        occupied[slot] = 1;
        vox_x[slot] = vx; vox_y[slot] = vy; vox_z[slot] = vz;
        fill[slot] = 0;
      end
      if (fill[slot] >= lim) begin
        a.status = ST_VOXEL_FULL;
        return a;
      end
      p = slot * PPS + fill[slot];
      pt_x[p] = px; pt_y[p] = py; pt_z[p] = pz;
      fill[slot]++;
      return a;
    end
    have = 0;
    best = 0;
    a.status = ST_QUERY;
    for (int i = 0; i < 27; i++) begin
      nx = longint'(vx) + SHX[i];
      ny = longint'(vy) + SHY[i];
      nz = longint'(vz) + SHZ[i];
      // skip neighbors past the signed coordinate range, no wrap
      if (nx < -8388608 || nx > 8388607 || ny < -8388608 || ny > 8388607 ||
          nz < -8388608 || nz > 8388607) continue;
      if (!probe(int'(nx), int'(ny), int'(nz), slot)) continue;
      for (int k = 0; k < fill[slot]; k++) begin
        p = slot * PPS + k;
        dx = longint'(pt_x[p]) - px;
        dy = longint'(pt_y[p]) - py;
        dz = longint'(pt_z[p]) - pz;
        d = dx * dx + dy * dy + dz * dz;
        if (!have || d < best) begin
          have = 1;
          best = d;
          a.nx = COORD_W'(pt_x[p]);
          a.ny = COORD_W'(pt_y[p]);
          a.nz = COORD_W'(pt_z[p]);
        end
      end
    end
    if (have) begin
      root = floor_root(best);
      a.found = 1;
      a.distance = (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
    end else a.distance = DIST_MAX;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      voxel_edge = VOXEL_SIZE_RST;
      point_cap = MAX_POINTS_RST;
      for (int s = 0; s < TS; s++) occupied[s] = 0;
      answers_due.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_VOXEL_SIZE) voxel_edge = cfg_wdata;
        else point_cap = cfg_wdata[MP_W-1:0];
      end
      if (req.valid && req.ready)
        answers_due = {answers_due, serve(req.kind, req.x_mm, req.y_mm, req.z_mm)};
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected response, status %0d", rsp.status);
          errors <= errors + 1;
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status || rsp.found !== want.found ||
              rsp.near_x !== want.nx || rsp.near_y !== want.ny ||
              rsp.near_z !== want.nz || rsp.distance !== want.distance) begin
            if (rsp.status !== want.status)
              $error("status: expected %0d actual %0d", want.status, rsp.status);
            if (rsp.found !== want.found)
              $error("found: expected %0d actual %0d", want.found, rsp.found);
            if (rsp.near_x !== want.nx)
              $error("near_x: expected %0d actual %0d", want.nx, rsp.near_x);
            if (rsp.near_y !== want.ny)
              $error("near_y: expected %0d actual %0d", want.ny, rsp.near_y);
            if (rsp.near_z !== want.nz)
              $error("near_z: expected %0d actual %0d", want.nz, rsp.near_z);
            if (rsp.distance !== want.distance)
              $error("distance: expected %0d actual %0d", want.distance, rsp.distance);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives inserts and nearest neighbor queries into the voxel map under
// several voxel sizes and point caps, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vmnn_pkg::*;

  localparam longint CYCLE_LIMIT = 60_000_000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic            cfg_addr = REG_VOXEL_SIZE;
  logic [VS_W-1:0] cfg_wdata = '0;
  int              errors, pending;
  longint          cycles = 0;
  bit              calm = 0;   // suppress all stalls while set

  vmnn_req_if req ();
  vmnn_rsp_if rsp ();

  initial begin
    req.valid = 1'b0;
    req.kind = KIND_INSERT;
    req.x_mm = '0;
    req.y_mm = '0;
    req.z_mm = '0;
    rsp.ready = 1'b0;
  end

  voxel_map_nearest_neighbor u_dut (
    .clk(clk), .rst_n(rst_n), .in_req(req), .out_rsp(rsp),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  vmnn_checker u_chk (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: stall with a probability of about 8 percent unless calm.
  always @(posedge clk)
    rsp.ready <= calm || ($urandom_range(99) >= 8);

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request and hold it until it is taken; maybe idle after.
  task automatic post(bit kind, int x, int y, int z);
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.x_mm  <= x[COORD_W-1:0];
    req.y_mm  <= y[COORD_W-1:0];
    req.z_mm  <= z[COORD_W-1:0];
    do @(posedge clk); while (!req.ready);
    if (!calm && $urandom_range(99) < 8) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drain all responses, let the block settle, then write both registers.
  task automatic set_regs(int unsigned vs, int unsigned mp);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= REG_VOXEL_SIZE; cfg_wdata <= vs[VS_W-1:0];
    @(posedge clk);
    cfg_addr <= REG_MAX_POINTS; cfg_wdata <= mp[VS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic int any24();
    return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
  endfunction

  int unsigned edges [6] = '{1000, 1, 65535, 0, 7, 250};
  int unsigned caps  [6] = '{20, 1, 32, 63, 3, 5};
  int hub_x [4], hub_y [4], hub_z [4];

  initial begin
    int unsigned spread, vs;
    int h, r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty map, voxel full, extremes, out-of-range neighbors.
    set_regs(3, 2);
    post(KIND_QUERY, 0, 0, 0);
    post(KIND_INSERT, 0, 0, 0);
    post(KIND_INSERT, 1, 1, 1);
    post(KIND_INSERT, 2, 2, 2);
    post(KIND_INSERT, 4, 0, 0);
    post(KIND_INSERT, -1, 0, 0);
    post(KIND_QUERY, 1, 0, 0);
    post(KIND_QUERY, 3, 0, 0);
    post(KIND_INSERT, 8388607, 8388607, 8388607);
    post(KIND_INSERT, -8388608, -8388608, -8388608);
    post(KIND_INSERT, -8388607, -8388606, -8388608);
    post(KIND_QUERY, -8388608, -8388608, -8388608);
    post(KIND_QUERY, 8388607, 8388607, 8388605);
    post(KIND_QUERY, 8388607, -8388608, 0);
    set_regs(0, 0);
    post(KIND_INSERT, 5, 5, 5);
    post(KIND_QUERY, 5, 5, 5);
    set_regs(65535, 63);
    post(KIND_INSERT, 65534, -65536, 0);
    post(KIND_INSERT, -65535, 65535, -1);
    post(KIND_QUERY, 0, 0, 0);
    post(KIND_QUERY, 131070, -131072, 65535);

    // Random: mostly points clustered around a few hubs so queries hit.
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(edges[ph], caps[ph]);
      vs = (edges[ph] == 0) ? 1 : edges[ph];
      spread = (vs > 100000) ? 200000 : 3 * vs + 4;
      for (int k = 0; k < 4; k++) begin
        hub_x[k] = any24(); hub_y[k] = any24(); hub_z[k] = any24();
      end
      for (int n = 0; n < 330; n++) begin
        calm = (ph == 2 && n >= 100 && n < 250);
        if (ph == 3 && n == 170) begin
          // hold off until the block has answered everything
          req.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        r = $urandom_range(99);
        if (r < 70) begin
          h = $urandom_range(3);
          post($urandom_range(1),
               clamp24(longint'(hub_x[h]) + $urandom_range(2 * spread) - spread),
               clamp24(longint'(hub_y[h]) + $urandom_range(2 * spread) - spread),
               clamp24(longint'(hub_z[h]) + $urandom_range(2 * spread) - spread));
        end else if (r < 88) post($urandom_range(1), any24(), any24(), any24());
        else post($urandom_range(1),
                  $urandom_range(1) ? 8388607 : -8388608 + $urandom_range(2),
                  $urandom_range(1) ? -8388608 : 8388607 - $urandom_range(2),
                  $urandom_range(1) ? 8388607 : -8388608);
      end
    end
    calm = 0;

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/vmnn_pkg.sv
hdl/vmnn_if.sv
hdl/vmnn_div.sv
hdl/vmnn_isqrt.sv
hdl/vmnn_slot_mem.sv
hdl/vmnn_point_mem.sv
hdl/voxel_map_nearest_neighbor.sv
sim/vmnn_checker.sv
sim/tb.sv
